// ===== src/lfc_pkg.sv =====
// Shared types, constants and tables of the linked feed-forward compressor.
// No dependencies; every other file of the block refers to this package.
package lfc_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int CHANNELS    = 2;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int GR_BITS     = 15;

   // shared multiplier operand widths
   localparam int MUL_A_BITS = 24;
   localparam int MUL_B_BITS = 19;
   localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

   localparam logic [14:0] GR_MAX      = 15'd24576;
   localparam logic [18:0] DB_PER_LOG2 = 19'd394566;
   localparam logic [18:0] LOG2_PER_DB = 19'd10885;

   localparam logic [CSR_IDX_BITS-1:0] CSR_COMP_ENABLE   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD_DB  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RATIO_SLOPE   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ATTACK_COEFF  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RELEASE_COEFF = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAKEUP_GAIN   = 3'd5;

   typedef struct packed {
      logic               comp_enable;
      logic signed [15:0] threshold_db;
      logic [15:0]        ratio_slope;
      logic [15:0]        attack_coeff;
      logic [15:0]        release_coeff;
      logic [15:0]        makeup_gain;
   } cfg_type;

   // 2^(-k/16), Q.16, k = 0..16
   function automatic logic [16:0] pow2_neg(input logic [4:0] k);
      logic [16:0] v;
      unique case (k)
         5'd0:  v = 17'd65536;
         5'd1:  v = 17'd62757;
         5'd2:  v = 17'd60097;
         5'd3:  v = 17'd57549;
         5'd4:  v = 17'd55109;
         5'd5:  v = 17'd52773;
         5'd6:  v = 17'd50535;
         5'd7:  v = 17'd48393;
         5'd8:  v = 17'd46341;
         5'd9:  v = 17'd44376;
         5'd10: v = 17'd42495;
         5'd11: v = 17'd40693;
         5'd12: v = 17'd38968;
         5'd13: v = 17'd37316;
         5'd14: v = 17'd35734;
         5'd15: v = 17'd34219;
         5'd16: v = 17'd32768;
         default: v = 17'd32768;
      endcase
      return v;
   endfunction

endpackage

// ===== src/lfc_req_if.sv =====
// Input frame channel: valid/ready handshake with one stereo frame.
// Depends on lfc_pkg for the sample width.
interface lfc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lfc_pkg::SAMPLE_BITS-1:0] sample_left;
   logic signed [lfc_pkg::SAMPLE_BITS-1:0] sample_right;

   modport source (output valid, sample_left, sample_right, input ready);
   modport sink   (input valid, sample_left, sample_right, output ready);
endinterface

// ===== src/lfc_rsp_if.sv =====
// Result channel: valid/ready handshake with gained samples and reduction.
// Depends on lfc_pkg for the field widths.
interface lfc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lfc_pkg::SAMPLE_BITS-1:0] out_left;
   logic signed [lfc_pkg::SAMPLE_BITS-1:0] out_right;
   logic [lfc_pkg::GR_BITS-1:0]          gain_reduction_db;

   modport source (output valid, out_left, out_right, gain_reduction_db, input ready);
   modport sink   (input valid, out_left, out_right, gain_reduction_db, output ready);
endinterface

// ===== src/lfc_csr.sv =====
// Configuration registers of the compressor, written through a plain port.
// Depends on lfc_pkg for register indexes and the cfg_type struct.
module lfc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [lfc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [lfc_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output lfc_pkg::cfg_type                  cfg
);

   lfc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lfc_pkg::CSR_COMP_ENABLE:   cfg_in.comp_enable   = csr_wdata[0];
            lfc_pkg::CSR_THRESHOLD_DB:  cfg_in.threshold_db  = $signed(csr_wdata);
            lfc_pkg::CSR_RATIO_SLOPE:   cfg_in.ratio_slope   = csr_wdata;
            lfc_pkg::CSR_ATTACK_COEFF:  cfg_in.attack_coeff  = csr_wdata;
            lfc_pkg::CSR_RELEASE_COEFF: cfg_in.release_coeff = csr_wdata;
            lfc_pkg::CSR_MAKEUP_GAIN:   cfg_in.makeup_gain   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.comp_enable   <= 1'b0;
         cfg_ff.threshold_db  <= 16'sd0;
         cfg_ff.ratio_slope   <= 16'd0;
         cfg_ff.attack_coeff  <= 16'd65535;
         cfg_ff.release_coeff <= 16'd65535;
         cfg_ff.makeup_gain   <= 16'd4096;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/lfc_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on lfc_pkg for the operand widths.
module lfc_mul (
   input  logic                            clock,
   input  logic [lfc_pkg::MUL_A_BITS-1:0]  op_a,
   input  logic [lfc_pkg::MUL_B_BITS-1:0]  op_b,
   output logic [lfc_pkg::MUL_P_BITS-1:0]  prod_ff
);

   logic [lfc_pkg::MUL_P_BITS-1:0] prod_in;

   assign prod_in = lfc_pkg::MUL_P_BITS'(op_a) * lfc_pkg::MUL_P_BITS'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== src/linked_feedforward_compressor.sv =====
// Linked stereo feed-forward compressor. One frame is taken while req is ready;
// the block then works on it alone and is not ready until the result transfers.
// All multiplications run through one registered multiplier under a sequencer:
// a compressed frame passes five normalize steps for the log detector, ten
// steps for level, target, smoothing and gain and three per channel for the
// output scaling before rsp valid; a silent frame skips the normalize, level
// and target steps, and a bypassed frame goes straight to rsp valid. The block
// is ready again the cycle after the result transfers.
// Depends on lfc_pkg, lfc_req_if, lfc_rsp_if, lfc_csr and lfc_mul.
module linked_feedforward_compressor (
   input  logic                              clock,
   input  logic                              reset,
   lfc_req_if.sink                           req_ch,
   lfc_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [lfc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [lfc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int SB = lfc_pkg::SAMPLE_BITS;
   localparam int PB = lfc_pkg::MUL_P_BITS;
   localparam logic [2:0] NORM_LAST = 3'd4;
   localparam logic       CH_LAST   = 1'b1;

   typedef enum logic [15:0] {
      ST_IDLE = 16'h0001,
      ST_NORM = 16'h0002,
      ST_LOGM = 16'h0004,
      ST_TGTM = 16'h0008,
      ST_TGT  = 16'h0010,
      ST_SMUL = 16'h0020,
      ST_SUPD = 16'h0040,
      ST_GMUL = 16'h0080,
      ST_IMUL = 16'h0100,
      ST_GAIN = 16'h0200,
      ST_TOTM = 16'h0400,
      ST_TOTL = 16'h0800,
      ST_MLO  = 16'h1000,
      ST_MHI  = 16'h2000,
      ST_ACC  = 16'h4000,
      ST_DONE = 16'h8000
   } state_type;

   lfc_pkg::cfg_type cfg;

   state_type state_ff, state_in;
   logic [23:0] sr_ff, sr_in;
   logic signed [SB-1:0] samp_ff [2];
   logic signed [SB-1:0] samp_in [2];
   logic [SB-1:0] mag_ff [2];
   logic [SB-1:0] mag_in [2];
   logic signed [SB-1:0] out_ff [2];
   logic signed [SB-1:0] out_in [2];
   logic [23:0] norm_ff, norm_in;
   logic [4:0]  lz_ff, lz_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [23:0] target_ff, target_in;
   logic        up_ff, up_in;
   logic [3:0]  k_ff, k_in;
   logic [5:0]  ip_ff, ip_in;
   logic [16:0] gain_ff, gain_in;
   logic [31:0] total_ff, total_in;
   logic [39:0] acc_ff, acc_in;
   logic        ch_ff, ch_in;

   logic [lfc_pkg::MUL_A_BITS-1:0] mul_a;
   logic [lfc_pkg::MUL_B_BITS-1:0] mul_b;
   logic [PB-1:0] prod_ff;

   logic [SB-1:0]  abs_l, abs_r, peak;
   logic           norm_zero;
   logic [4:0]     amt;
   logic [20:0]    neg_log;
   logic [40:0]    nd_sum;
   logic [15:0]    nd;
   logic signed [17:0] thr_sum;
   logic [16:0]    excess;
   logic [16:0]    t_raw;
   logic [14:0]    t_sat;
   logic           up;
   logic [23:0]    diff;
   logic [40:0]    step_sum;
   logic [23:0]    step;
   logic [16:0]    g_interp;
   logic [56:0]    out_sum;
   logic [28:0]    r;
   logic [24:0]    sr_rnd;

   lfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lfc_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   assign abs_l = req_ch.sample_left[SB-1]  ? SB'(-req_ch.sample_left)  : req_ch.sample_left;
   assign abs_r = req_ch.sample_right[SB-1] ? SB'(-req_ch.sample_right) : req_ch.sample_right;
   assign peak  = (abs_l > abs_r) ? abs_l : abs_r;

   // binary normalize: test the top 16, 8, 4, 2, 1 bits in turn
   always_comb begin
      unique case (cnt_ff)
         3'd0: begin amt = 5'd16; norm_zero = (norm_ff[23:8]  == 16'd0); end
         3'd1: begin amt = 5'd8;  norm_zero = (norm_ff[23:16] == 8'd0);  end
         3'd2: begin amt = 5'd4;  norm_zero = (norm_ff[23:20] == 4'd0);  end
         3'd3: begin amt = 5'd2;  norm_zero = (norm_ff[23:22] == 2'd0);  end
         default: begin amt = 5'd1; norm_zero = ~norm_ff[23]; end
      endcase
   end

   assign neg_log  = {lz_ff, 16'd0} - 21'(norm_ff[22:7]);
   assign nd_sum   = 41'(prod_ff[39:0]) + 41'd8388608;
   assign nd       = nd_sum[39:24];
   assign thr_sum  = 18'(cfg.threshold_db) + $signed({2'b00, nd});
   assign excess   = thr_sum[17] ? 17'(-thr_sum) : 17'd0;
   assign t_raw    = prod_ff[32:16];
   assign t_sat    = (t_raw > 17'(lfc_pkg::GR_MAX)) ? lfc_pkg::GR_MAX : t_raw[14:0];
   assign up       = target_ff > sr_ff;
   assign diff     = up ? (target_ff - sr_ff) : (sr_ff - target_ff);
   assign step_sum = 41'(prod_ff[39:0]) + 41'd32768;
   assign step     = step_sum[39:16];
   assign g_interp = lfc_pkg::pow2_neg({1'b0, k_ff}) - 17'(prod_ff[23:12]);
   assign out_sum  = 57'(acc_ff) + {1'b0, prod_ff[39:0], 16'd0} + 57'd134217728;
   assign r        = out_sum[56:28];

   always_comb begin
      state_in  = state_ff;
      sr_in     = sr_ff;
      samp_in   = samp_ff;
      mag_in    = mag_ff;
      out_in    = out_ff;
      norm_in   = norm_ff;
      lz_in     = lz_ff;
      cnt_in    = cnt_ff;
      target_in = target_ff;
      up_in     = up_ff;
      k_in      = k_ff;
      ip_in     = ip_ff;
      gain_in   = gain_ff;
      total_in  = total_ff;
      acc_in    = acc_ff;
      ch_in     = ch_ff;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               samp_in[0] = req_ch.sample_left;
               samp_in[1] = req_ch.sample_right;
               mag_in[0]  = abs_l;
               mag_in[1]  = abs_r;
               if (!cfg.comp_enable) begin
                  out_in[0] = req_ch.sample_left;
                  out_in[1] = req_ch.sample_right;
                  state_in  = ST_DONE;
               end else if (peak == '0) begin
                  // silent frame: no target
                  target_in = 24'd0;
                  state_in  = ST_SMUL;
               end else begin
                  norm_in  = peak;
                  lz_in    = 5'd0;
                  cnt_in   = 3'd0;
                  state_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            if (norm_zero) begin
               norm_in = norm_ff << amt;
               lz_in   = lz_ff + amt;
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == NORM_LAST) state_in = ST_LOGM;
         end
         ST_LOGM: begin
            mul_a    = 24'(neg_log);
            mul_b    = lfc_pkg::DB_PER_LOG2;
            state_in = ST_TGTM;
         end
         ST_TGTM: begin
            mul_a    = 24'(excess);
            mul_b    = 19'(cfg.ratio_slope);
            state_in = ST_TGT;
         end
         ST_TGT: begin
            target_in = {1'b0, t_sat, 8'd0};
            state_in  = ST_SMUL;
         end
         ST_SMUL: begin
            up_in    = up;
            mul_a    = diff;
            mul_b    = up ? 19'(cfg.attack_coeff) : 19'(cfg.release_coeff);
            state_in = ST_SUPD;
         end
         ST_SUPD: begin
            sr_in    = up_ff ? (sr_ff + step) : (sr_ff - step);
            state_in = ST_GMUL;
         end
         ST_GMUL: begin
            mul_a    = sr_ff;
            mul_b    = lfc_pkg::LOG2_PER_DB;
            state_in = ST_IMUL;
         end
         ST_IMUL: begin
            k_in     = prod_ff[31:28];
            ip_in    = prod_ff[37:32];
            mul_a    = 24'(lfc_pkg::pow2_neg({1'b0, prod_ff[31:28]})
                         - lfc_pkg::pow2_neg(5'({1'b0, prod_ff[31:28]}) + 5'd1));
            mul_b    = 19'(prod_ff[27:16]);
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            gain_in  = g_interp >> ip_ff;
            state_in = ST_TOTM;
         end
         ST_TOTM: begin
            mul_a    = 24'(gain_ff);
            mul_b    = 19'(cfg.makeup_gain);
            state_in = ST_TOTL;
         end
         ST_TOTL: begin
            total_in = prod_ff[31:0];
            ch_in    = 1'b0;
            state_in = ST_MLO;
         end
         ST_MLO: begin
            mul_a    = mag_ff[ch_ff];
            mul_b    = 19'(total_ff[15:0]);
            state_in = ST_MHI;
         end
         ST_MHI: begin
            acc_in   = prod_ff[39:0];
            mul_a    = mag_ff[ch_ff];
            mul_b    = 19'(total_ff[31:16]);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // round half away from zero, then saturate
            if (samp_ff[ch_ff][SB-1]) begin
               out_in[ch_ff] = (r > 29'(1 << (SB - 1))) ? {1'b1, {(SB-1){1'b0}}}
                                                         : SB'(-r);
            end else begin
               out_in[ch_ff] = (r > 29'((1 << (SB - 1)) - 1)) ? {1'b0, {(SB-1){1'b1}}}
                                                               : SB'(r);
            end
            if (ch_ff == CH_LAST) begin
               state_in = ST_DONE;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_MLO;
            end
         end
         ST_DONE: begin
            if (rsp_ch.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sr_ff    <= 24'd0;
      end else begin
         state_ff <= state_in;
         sr_ff    <= sr_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_ff   <= samp_in;
      mag_ff    <= mag_in;
      out_ff    <= out_in;
      norm_ff   <= norm_in;
      lz_ff     <= lz_in;
      cnt_ff    <= cnt_in;
      target_ff <= target_in;
      up_ff     <= up_in;
      k_ff      <= k_in;
      ip_ff     <= ip_in;
      gain_ff   <= gain_in;
      total_ff  <= total_in;
      acc_ff    <= acc_in;
      ch_ff     <= ch_in;
   end

   assign sr_rnd = 25'(sr_ff) + 25'd128;

   assign req_ch.ready             = (state_ff == ST_IDLE);
   assign rsp_ch.valid             = (state_ff == ST_DONE);
   assign rsp_ch.out_left          = out_ff[0];
   assign rsp_ch.out_right         = out_ff[1];
   assign rsp_ch.gain_reduction_db = sr_rnd[22:8];

endmodule
